FILE: src/upc_pkg.sv
// ----------------------------------------------------------------------------
// upc_pkg: shared types, constants and helper functions
// Holds the transaction payload types, the mode and hold-state codes and the
// character classification functions for the URL percent codec.
// ----------------------------------------------------------------------------
package upc_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } out_item_t;

  // Results caused by one input item: up to three bytes, their count and the
  // end-of-string flag of the item that caused them.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } res_t;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_PCT  = 2'd1;
  localparam logic [1:0] PEND_HIGH = 2'd2;

  localparam logic [1:0] CNT_ZERO  = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_USCR  = 8'h5F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;
  localparam logic [7:0] CASE_GAP   = 8'd32;
  localparam logic [7:0] HEX_ALPHA  = 8'd55;

  // Unreserved characters are copied through by the encoder.
  function automatic logic passes_through(input logic [7:0] b);
    logic res;
    res = (b inside {[CHAR_ZERO:CHAR_NINE], [CHAR_UA:CHAR_UZ], [CHAR_LA:CHAR_LZ]}) ||
          (b == CHAR_DASH) || (b == CHAR_USCR) || (b == CHAR_DOT) || (b == CHAR_TILDE);
    return res;
  endfunction

  // Uppercase hex character for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = CHAR_ZERO + {4'd0, nib};
    end else begin
      res = CHAR_UA + {4'd0, nib} - 8'd10;
    end
    return res;
  endfunction

  // Lenient hex digit value, modulo 256.
  function automatic logic [7:0] lenient_hex(input logic [7:0] b);
    logic [7:0] res;
    if (b inside {[CHAR_ZERO:CHAR_NINE]}) begin
      res = b - CHAR_ZERO;
    end else if (b inside {[CHAR_LA:CHAR_LZ]}) begin
      res = b - CASE_GAP - HEX_ALPHA;
    end else begin
      res = b - HEX_ALPHA;
    end
    return res;
  endfunction

endpackage

FILE: src/upc_skid.sv
// ----------------------------------------------------------------------------
// upc_skid: two-entry input buffer
// Registers incoming transactions so that the input stall is a flop output
// and a new transaction can still be taken in every cycle while it is not full.
// ----------------------------------------------------------------------------
module upc_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  upc_pkg::in_item_t data_i,
  output logic              avail_o,
  output upc_pkg::in_item_t head_o,
  input  logic              pop_i
);
  import upc_pkg::*;

  in_item_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign stall_o = (count_q == 2'd2);
  assign avail_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign push    = valid_i && !stall_o;
  assign pop     = pop_i && avail_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: src/upc_xlate.sv
// ----------------------------------------------------------------------------
// upc_xlate: encode / decode step
// Holds the mode register and the decoder's held-percent state, and works
// out the results of one input transaction.
// ----------------------------------------------------------------------------
module upc_xlate (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_mode_i,
  input  upc_pkg::in_item_t item_i,
  input  logic              fire_i,
  output upc_pkg::res_t     res_o
);
  import upc_pkg::*;

  logic       mode_q, mode_d;
  logic [1:0] pend_q, pend_d;
  logic [7:0] held_q, held_d;
  logic [7:0] b;
  logic       last;
  logic [7:0] hi_val;
  logic [7:0] lo_val;
  logic [7:0] dec_val;

  assign b       = item_i.in_byte;
  assign last    = item_i.in_last;
  assign hi_val  = lenient_hex(held_q);
  assign lo_val  = lenient_hex(b);
  assign dec_val = {hi_val[3:0], 4'd0} + lo_val;

  always_comb begin
    res_o.bytes = '0;
    res_o.cnt   = CNT_ZERO;
    res_o.last  = last;
    pend_d      = pend_q;
    held_d      = held_q;
    if (mode_q == MODE_ENCODE) begin
      pend_d = PEND_NONE;
      held_d = '0;
      if (passes_through(b)) begin
        res_o.bytes[0] = b;
        res_o.cnt      = CNT_ONE;
      end else begin
        res_o.bytes[0] = CHAR_PCT;
        res_o.bytes[1] = hex_char(b[7:4]);
        res_o.bytes[2] = hex_char(b[3:0]);
        res_o.cnt      = CNT_THREE;
      end
    end else begin
      case (pend_q)
        PEND_HIGH: begin
          res_o.bytes[0] = dec_val;
          res_o.cnt      = CNT_ONE;
          pend_d         = PEND_NONE;
          held_d         = '0;
        end
        PEND_PCT: begin
          if (last) begin
            res_o.bytes[0] = CHAR_PCT;
            res_o.bytes[1] = b;
            res_o.cnt      = CNT_TWO;
            pend_d         = PEND_NONE;
          end else begin
            held_d = b;
            pend_d = PEND_HIGH;
          end
        end
        default: begin
          if (b == CHAR_PCT && !last) begin
            pend_d = PEND_PCT;
          end else begin
            res_o.bytes[0] = b;
            res_o.cnt      = CNT_ONE;
          end
        end
      endcase
      if (last) begin
        pend_d = PEND_NONE;
        held_d = '0;
      end
    end
    mode_d = mode_q;
    if (cfg_we_i) begin
      mode_d = cfg_mode_i;
      pend_d = PEND_NONE;
      held_d = '0;
    end else if (!fire_i) begin
      pend_d = pend_q;
      held_d = held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENCODE;
      pend_q <= PEND_NONE;
      held_q <= '0;
    end else begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      held_q <= held_d;
    end
  end

  // The hold state never takes its unused code.
  a_pend_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == PEND_NONE) || (pend_q == PEND_PCT) || (pend_q == PEND_HIGH))
    else $error("hold state took an unused code");

  // Nothing is ever held while encoding.
  a_enc_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_ENCODE) |-> (pend_q == PEND_NONE))
    else $error("hold state set in encode mode");

  // A register write always drops any held percent sequence.
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (pend_q == PEND_NONE) && (held_q == 8'd0))
    else $error("hold state survived a mode write");

endmodule

FILE: src/url_percent_codec_top.sv
// ----------------------------------------------------------------------------
// url_percent_codec_top: streaming URL percent encoder / decoder
// Converts a byte string to or from percent encoding, one input transaction
// per byte, with up to three output transactions for each of them.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid_i / in_stall_o with in_data_i (byte and last flag).
//   Output channel: out_valid_o / out_stall_i with out_o (byte, run_end,
//   string_end). A transaction moves on an edge where valid is high and stall
//   is low. run_end marks the final output caused by one input byte, and
//   string_end the final output of a whole string.
//   Configuration: cfg_valid_i / cfg_ready_o with cfg_data_i carrying the mode
//   bit (0 encode, 1 decode). Write it only while the block is idle; a write
//   also drops any percent sequence that the decoder holds.
//   Timing: an input item passes through the input buffer register and then
//   the result buffer register, from which its outputs are offered.
//   Throughput: one input byte per cycle when it yields one output and the
//   output is not stalled; an escaped byte in encode mode needs three one-byte
//   output transactions. A held '%' or high digit yields nothing.
//   Reset puts the block in encode mode with nothing held and both buffers
//   empty. When the receiver stalls, the current output is held steady, the
//   two-entry input buffer fills, and in_stall_o rises once it is full.
// ----------------------------------------------------------------------------
module url_percent_codec_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  upc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output upc_pkg::out_item_t out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import upc_pkg::*;

  in_item_t   head;
  logic       head_avail;
  logic       pop;
  res_t       res_new;
  res_t       res_q;
  logic       buf_valid_q, buf_valid_d;
  logic [1:0] idx_q, idx_d;
  logic       run_end;
  logic       take;
  logic       buf_free;

  // The mode register is always ready; the user must make writes only while idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  upc_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .avail_o (head_avail),
    .head_o  (head),
    .pop_i   (pop)
  );

  upc_xlate u_xlate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_mode_i (cfg_data_i),
    .item_i     (head),
    .fire_i     (pop),
    .res_o      (res_new)
  );

  // The result buffer walks through the stored bytes one per output
  // transaction. It reloads in the same cycle that its final byte leaves, so
  // single-result items stream at full rate.
  assign run_end     = (idx_q == (res_q.cnt - 2'd1));
  assign out_valid_o = buf_valid_q;
  assign take        = out_valid_o && !out_stall_i;
  assign buf_free    = !buf_valid_q || (take && run_end);
  assign pop         = head_avail && buf_free;

  always_comb begin
    out_o.out_byte   = res_q.bytes[idx_q];
    out_o.run_end    = run_end;
    out_o.string_end = run_end && res_q.last;
  end

  always_comb begin
    buf_valid_d = buf_valid_q;
    idx_d       = idx_q;
    if (pop) begin
      // An item that only adds to the held sequence leaves the buffer empty.
      buf_valid_d = (res_new.cnt != CNT_ZERO);
      idx_d       = 2'd0;
    end else if (take && run_end) begin
      buf_valid_d = 1'b0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      buf_valid_q <= buf_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_q <= res_new;
    end
  end

  // The end of a string is always the end of an item's run.
  a_str_end_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.string_end) |-> out_o.run_end)
    else $error("string end without run end");

  // A full buffer always holds at least one result.
  a_buf_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_valid_q |-> (res_q.cnt != CNT_ZERO))
    else $error("result buffer valid with no results");

  // The read position stays inside the stored results.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_valid_q |-> (idx_q < res_q.cnt))
    else $error("result index past the stored results");

endmodule
